// ===== rtl/ffrt_pkg.sv =====
// Shared types and constants for the FASTA/FASTQ record tokenizer.
`timescale 1ns / 1ps

package ffrt_pkg;

    // Counter width and the saturating counter width (capped at 32 bits)
    localparam int LENGTH_WIDTH = 32;
    localparam int CNT_W        = (LENGTH_WIDTH >= 32) ? 32 : LENGTH_WIDTH;
    localparam int LEN_OUT_W    = 32;

    // Result queue between parser and output stage
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Port packing
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 112;
    localparam int OUT_USER_W = 2;
    localparam int OUT_PAD_W  = OUT_DATA_W - (8 + 3 * LEN_OUT_W + 2);

    // Characters
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] MARK_FASTA = 8'd62;
    localparam logic [7:0] MARK_FASTQ = 8'd64;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_IDENT   = 2'd0,
        KIND_SEQ     = 2'd1,
        KIND_QUAL    = 2'd2,
        KIND_SUMMARY = 2'd3
    } t_kind;

    // One result item
    typedef struct packed {
        t_kind                  kind;
        logic [7:0]             data;
        logic [LEN_OUT_W-1:0]   ident_len;
        logic [LEN_OUT_W-1:0]   seq_len;
        logic [LEN_OUT_W-1:0]   quality_len;
        logic                   rec_valid;
        logic                   fastq;
        logic                   last;
    } t_result;

    // Everything one input byte produces: one result, or two when dual is set
    typedef struct packed {
        logic    dual;
        t_result first;
        t_result second;
    } t_entry;

endpackage

// ===== rtl/ffrt_front.sv =====
// Parser front end: accepts bytes, tracks record phase and counters, builds result entries.
`timescale 1ns / 1ps

module ffrt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_byte,
    input  logic              i_eos,
    input  logic              i_full,
    output logic              o_push,
    output ffrt_pkg::t_entry  o_entry,
    output logic              o_halted
);
    import ffrt_pkg::*;

    typedef enum logic [3:0] {
        PH_FIRST  = 4'd0,
        PH_START  = 4'd1,
        PH_IDENT  = 4'd2,
        PH_HDR    = 4'd3,
        PH_FSEQ   = 4'd4,
        PH_QSEQW  = 4'd5,
        PH_QSEQ   = 4'd6,
        PH_QPLUSW = 4'd7,
        PH_QPLUS  = 4'd8,
        PH_QQUALW = 4'd9,
        PH_QQUAL  = 4'd10
    } t_phase;

    t_phase           r_phase, n_phase;
    logic             r_fastq, n_fastq;
    logic             r_halted, n_halted;
    logic [CNT_W-1:0] r_ident, n_ident;
    logic [CNT_W-1:0] r_seq, n_seq;
    logic [CNT_W-1:0] r_trim, n_trim;
    logic [CNT_W-1:0] r_qual, n_qual;

    logic   w_accept;
    t_entry w_entry;
    logic   w_any;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

    function automatic t_result make_sum(input logic [CNT_W-1:0] id,
                                         input logic [CNT_W-1:0] tr,
                                         input logic [CNT_W-1:0] qu,
                                         input logic             fq);
        t_result r;
        r             = '0;
        r.kind        = KIND_SUMMARY;
        r.ident_len   = LEN_OUT_W'(id);
        r.seq_len     = LEN_OUT_W'(tr);
        r.quality_len = fq ? LEN_OUT_W'(qu) : '0;
        r.rec_valid   = (id != '0) && (tr != '0);
        r.fastq       = fq;
        return r;
    endfunction

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;

    // Next-state and result building for one byte
    always_comb begin
        logic             consumed;
        logic             lf;
        logic             cr;
        logic             open_rec;
        logic             item_v;
        logic             fsum_v;
        logic             esum_v;
        logic             fq;
        logic [CNT_W-1:0] seq_inc;
        t_result          item;
        t_result          fsum;
        t_result          esum;

        n_phase  = r_phase;
        n_fastq  = r_fastq;
        n_halted = r_halted;
        n_ident  = r_ident;
        n_seq    = r_seq;
        n_trim   = r_trim;
        n_qual   = r_qual;
        consumed = 1'b0;
        open_rec = 1'b0;
        item_v   = 1'b0;
        fsum_v   = 1'b0;
        esum_v   = 1'b0;
        lf       = (i_byte == CH_LF);
        cr       = (i_byte == CH_CR);
        seq_inc  = sat_inc(r_seq);
        item     = '0;
        item.data = i_byte;
        fsum     = make_sum(r_ident, r_trim, r_qual, r_fastq);

        if (!r_halted) begin
            // first byte picks the format
            if (r_phase == PH_FIRST) begin
                if (i_byte == MARK_FASTQ) begin
                    n_fastq  = 1'b1;
                    open_rec = 1'b1;
                    consumed = 1'b1;
                end else begin
                    n_fastq = 1'b0;
                    n_phase = PH_START;
                end
            end
            if (!consumed) begin
                case (n_phase)
                    PH_START: begin
                        if (lf || cr || (n_fastq && i_byte == CH_SPACE)) begin
                            n_phase = PH_START;
                        end else if (i_byte == (n_fastq ? MARK_FASTQ : MARK_FASTA)) begin
                            open_rec = 1'b1;
                        end else begin
                            n_halted = 1'b1;
                        end
                    end
                    PH_IDENT: begin
                        if (i_byte == CH_SPACE || i_byte == CH_TAB || cr) begin
                            n_phase = PH_HDR;
                        end else if (lf) begin
                            n_phase = n_fastq ? PH_QSEQW : PH_FSEQ;
                        end else begin
                            n_ident   = sat_inc(r_ident);
                            item_v    = 1'b1;
                            item.kind = KIND_IDENT;
                        end
                    end
                    PH_HDR: begin
                        if (lf) begin
                            n_phase = n_fastq ? PH_QSEQW : PH_FSEQ;
                        end
                    end
                    PH_FSEQ: begin
                        if (i_byte == MARK_FASTA) begin
                            fsum_v   = 1'b1;
                            open_rec = 1'b1;
                        end else if (!lf && !cr) begin
                            n_seq     = seq_inc;
                            n_trim    = (i_byte != CH_SPACE) ? seq_inc : r_trim;
                            item_v    = 1'b1;
                            item.kind = KIND_SEQ;
                        end
                    end
                    PH_QSEQW, PH_QSEQ: begin
                        if (lf && n_phase == PH_QSEQ) begin
                            n_phase = PH_QPLUSW;
                        end else if (!lf && !cr) begin
                            n_seq     = seq_inc;
                            n_trim    = (i_byte != CH_SPACE) ? seq_inc : r_trim;
                            item_v    = 1'b1;
                            item.kind = KIND_SEQ;
                            n_phase   = PH_QSEQ;
                        end
                    end
                    PH_QPLUSW: begin
                        if (!lf && !cr) begin
                            n_phase = PH_QPLUS;
                        end
                    end
                    PH_QPLUS: begin
                        if (lf) begin
                            n_phase = PH_QQUALW;
                        end
                    end
                    PH_QQUALW, PH_QQUAL: begin
                        if (lf && n_phase == PH_QQUAL) begin
                            fsum_v  = 1'b1;
                            n_phase = PH_START;
                        end else if (!lf && !cr) begin
                            n_qual    = sat_inc(r_qual);
                            item_v    = 1'b1;
                            item.kind = KIND_QUAL;
                            n_phase   = PH_QQUAL;
                        end
                    end
                    default: begin
                        n_halted = 1'b1;
                    end
                endcase
            end
            // a new record clears the counters
            if (open_rec) begin
                n_ident = '0;
                n_seq   = '0;
                n_trim  = '0;
                n_qual  = '0;
                n_phase = PH_IDENT;
            end
        end

        fq         = n_fastq;
        item.fastq = fq;
        fsum.fastq = fq;
        esum       = make_sum(n_ident, n_trim, n_qual, fq);

        // end of stream closes an open record and restarts the parser
        if (i_eos) begin
            esum_v   = !n_halted && (n_phase inside {[PH_IDENT:PH_QQUAL]});
            n_phase  = PH_FIRST;
            n_fastq  = 1'b0;
            n_halted = 1'b0;
            n_ident  = '0;
            n_seq    = '0;
            n_trim   = '0;
            n_qual   = '0;
        end

        w_entry.dual   = (item_v || fsum_v) && esum_v;
        w_entry.first  = item_v ? item : (fsum_v ? fsum : esum);
        w_entry.second = esum;
        if (i_eos) begin
            if (w_entry.dual) begin
                w_entry.second.last = 1'b1;
            end else begin
                w_entry.first.last = 1'b1;
            end
        end
        w_any = item_v || fsum_v || esum_v;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_FIRST;
            r_fastq  <= 1'b0;
            r_halted <= 1'b0;
            r_ident  <= '0;
            r_seq    <= '0;
            r_trim   <= '0;
            r_qual   <= '0;
        end else if (w_accept) begin
            r_phase  <= n_phase;
            r_fastq  <= n_fastq;
            r_halted <= n_halted;
            r_ident  <= n_ident;
            r_seq    <= n_seq;
            r_trim   <= n_trim;
            r_qual   <= n_qual;
        end
    end

    assign o_push   = w_accept && w_any;
    assign o_entry  = w_entry;
    assign o_halted = r_halted;

endmodule

// ===== rtl/ffrt_queue.sv =====
// Short entry queue between the parser and the output stage.
`timescale 1ns / 1ps

module ffrt_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ffrt_pkg::t_entry  i_entry,
    input  logic              i_pop,
    output ffrt_pkg::t_entry  o_head,
    output logic              o_full,
    output logic              o_empty
);
    import ffrt_pkg::*;

    t_entry            r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head  = r_slot[r_rd_ptr];
    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);

endmodule

// ===== rtl/ffrt_back.sv =====
// Output stage: unrolls queue entries into result items behind an output register.
`timescale 1ns / 1ps

module ffrt_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ffrt_pkg::t_entry   i_head,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output ffrt_pkg::t_result  o_result
);
    import ffrt_pkg::*;

    logic    r_valid;
    logic    r_second;
    t_result r_out;
    logic    w_load;
    logic    w_take_first;

    assign w_load       = !r_valid || i_ready;
    // the first half of a two-result entry leaves the entry in the queue
    assign w_take_first = i_head.dual && !r_second;
    assign o_pop        = w_load && !i_empty && !w_take_first;

    // Output register and half-entry flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (w_load) begin
            r_valid <= !i_empty;
            if (!i_empty) begin
                r_second <= w_take_first;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && !i_empty) begin
            r_out <= (i_head.dual && r_second) ? i_head.second : i_head.first;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule

// ===== rtl/fasta_fastq_record_tokenizer.sv =====
// Top level of the FASTA/FASTQ record tokenizer.
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+-----------------------------------------
//  s       | in  | i_s_tvalid / o_s_tready   | tdata: data_byte; tlast: end_of_stream
//  m       | out | o_m_tvalid / i_m_tready   | tdata: out_byte, lengths, flags;
//          |     |                           | tuser: item_kind; tlast: final_item
//
// One byte is accepted per cycle unless the queue is full; results pass through the queue and
// then the output register. A byte that yields two results (end of stream closing a record) is
// one queue entry unrolled into two items. The output register drains one result per cycle while
// the receiver is ready; output stalls back up into the four-entry queue, which sets the slack.
// Reset clears the parser state, the queue pointers and the output valid.
`timescale 1ns / 1ps

module fasta_fastq_record_tokenizer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // [7:0] data_byte
    input  logic [7:0]   i_s_tdata,
    input  logic         i_s_tlast,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [7:0] out_byte, [39:8] ident_length, [71:40] seq_length,
    // [103:72] quality_length, [104] record_valid, [105] fastq_mode, [111:106] zero
    output logic [111:0] o_m_tdata,
    // [1:0] item_kind
    output logic [1:0]   o_m_tuser,
    output logic         o_m_tlast
);
    import ffrt_pkg::*;

    logic    w_push;
    logic    w_pop;
    logic    w_full;
    logic    w_empty;
    logic    w_halted;
    t_entry  w_entry;
    t_entry  w_head;
    t_result w_result;

    // Parser front end
    ffrt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_byte   (i_s_tdata),
        .i_eos    (i_s_tlast),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_entry  (w_entry),
        .o_halted (w_halted)
    );

    // Decoupling queue
    ffrt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // Output stage
    ffrt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (w_result)
    );

    // Port packing
    assign o_m_tdata = {{OUT_PAD_W{1'b0}}, w_result.fastq, w_result.rec_valid,
                        w_result.quality_len, w_result.seq_len, w_result.ident_len,
                        w_result.data};
    assign o_m_tuser = w_result.kind;
    assign o_m_tlast = w_result.last;

    // Queue never written while full, never read while empty
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("queue read while empty");

    // A halted parser produces nothing until the stream ends
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_halted |-> !w_push)
        else $error("result produced while halted");

    // Byte items carry no lengths and no valid flag
    a_item_no_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != KIND_SUMMARY) |-> (o_m_tdata[104:8] == '0))
        else $error("byte item carries summary fields");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the FASTA/FASTQ record tokenizer.
`timescale 1ns / 1ps

module tb;
    import ffrt_pkg::*;

    localparam int LONG_HOLD    = 64;    // receiver hold-off, in cycles
    localparam int QUIET_LIMIT  = 4000;  // cycles without any item before giving up
    localparam int TAIL_CYCLES  = 16;    // drain time after the last item
    localparam int PHASE_BYTES  = 600;   // bytes per idling phase

    // Parser phases of the tokenizer
    typedef enum logic [3:0] {
        P_FIRST_BYTE, P_REC_START, P_IDENT, P_HEADER, P_FASTA_SEQ,
        P_SEQ_WAIT, P_SEQ, P_PLUS_WAIT, P_PLUS, P_QUAL_WAIT, P_QUAL
    } t_parse_phase;

    // One row of the directed script
    typedef struct {
        logic [7:0] data;
        logic       eos;
        logic       typed;      // expectation written into the row
        logic       has_token;  // typed row yields one item, else none
        t_result    token;
    } t_script_row;

    logic         i_clk      = 1'b0;
    logic         i_rst_n    = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [7:0]   i_s_tdata  = 8'h00;   // [7:0] data_byte
    logic         i_s_tlast  = 1'b0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    // [7:0] out_byte, [39:8] ident_length, [71:40] seq_length,
    // [103:72] quality_length, [104] record_valid, [105] fastq_mode, [111:106] zero
    logic [111:0] o_m_tdata;
    logic [1:0]   o_m_tuser;             // [1:0] item_kind
    logic         o_m_tlast;

    fasta_fastq_record_tokenizer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shared bookkeeping
    t_result      expected_tokens[$];
    logic [7:0]   stream_bytes[$];
    t_script_row  directed_rows[$];
    int           mismatch_count = 0;
    int           bytes_sent     = 0;
    int           send_idle_pct  = 14;
    int           recv_idle_pct  = 88;
    int           hold_requests  = 0;

    // ------------------------------------------------------------------
    // Tokenizer predictor
    // ------------------------------------------------------------------
    t_parse_phase         phase;
    logic                 fq_mode;
    logic                 halted;
    logic [LEN_OUT_W-1:0] id_len, seq_len, seq_kept, qual_cnt;
    t_result              step_tokens[2];
    int                   step_count;

    function automatic logic [LEN_OUT_W-1:0] sat_inc(input logic [LEN_OUT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic void reset_parser();
        phase    = P_FIRST_BYTE;
        fq_mode  = 1'b0;
        halted   = 1'b0;
        id_len   = '0;
        seq_len  = '0;
        seq_kept = '0;
        qual_cnt = '0;
    endfunction

    function automatic void open_record();
        id_len   = '0;
        seq_len  = '0;
        seq_kept = '0;
        qual_cnt = '0;
        phase    = P_IDENT;
    endfunction

    function automatic void emit_byte(input t_kind kind, input logic [7:0] b);
        t_result r;
        r       = '0;
        r.kind  = kind;
        r.data  = b;
        r.fastq = fq_mode;
        step_tokens[step_count] = r;
        step_count++;
    endfunction

    function automatic void emit_summary();
        t_result r;
        r             = '0;
        r.kind        = KIND_SUMMARY;
        r.ident_len   = id_len;
        r.seq_len     = seq_kept;
        r.quality_len = fq_mode ? qual_cnt : '0;
        r.rec_valid   = (id_len != 0) && (seq_kept != 0);
        r.fastq       = fq_mode;
        step_tokens[step_count] = r;
        step_count++;
    endfunction

    // Sequence byte: tagged always, trailing spaces left out of the length
    function automatic void take_seq(input logic [7:0] b);
        seq_len = sat_inc(seq_len);
        if (b != CH_SPACE) seq_kept = seq_len;
        emit_byte(KIND_SEQ, b);
    endfunction

    function automatic void tokenize_byte(input logic [7:0] b, input logic eos);
        logic lf, cr, consumed;
        lf         = (b == CH_LF);
        cr         = (b == CH_CR);
        consumed   = 1'b0;
        step_count = 0;
        if (!halted) begin
            // first byte of a stream picks the format
            if (phase == P_FIRST_BYTE) begin
                if (b == MARK_FASTQ) begin
                    fq_mode = 1'b1;
                    open_record();
                    consumed = 1'b1;
                end else begin
                    fq_mode = 1'b0;
                    phase   = P_REC_START;
                end
            end
            if (!consumed) begin
                case (phase)
                    P_REC_START: begin
                        if (!(lf || cr || (fq_mode && b == CH_SPACE))) begin
                            if (b == (fq_mode ? MARK_FASTQ : MARK_FASTA)) open_record();
                            else halted = 1'b1;
                        end
                    end
                    P_IDENT: begin
                        if (b == CH_SPACE || b == CH_TAB || cr) begin
                            phase = P_HEADER;
                        end else if (lf) begin
                            phase = fq_mode ? P_SEQ_WAIT : P_FASTA_SEQ;
                        end else begin
                            id_len = sat_inc(id_len);
                            emit_byte(KIND_IDENT, b);
                        end
                    end
                    P_HEADER: begin
                        if (lf) phase = fq_mode ? P_SEQ_WAIT : P_FASTA_SEQ;
                    end
                    P_FASTA_SEQ: begin
                        if (b == MARK_FASTA) begin
                            emit_summary();
                            open_record();
                        end else if (!lf && !cr) begin
                            take_seq(b);
                        end
                    end
                    P_SEQ_WAIT: begin
                        if (!lf && !cr) begin
                            take_seq(b);
                            phase = P_SEQ;
                        end
                    end
                    P_SEQ: begin
                        if (lf) phase = P_PLUS_WAIT;
                        else if (!cr) take_seq(b);
                    end
                    P_PLUS_WAIT: begin
                        if (!lf && !cr) phase = P_PLUS;
                    end
                    P_PLUS: begin
                        if (lf) phase = P_QUAL_WAIT;
                    end
                    P_QUAL_WAIT: begin
                        if (!lf && !cr) begin
                            qual_cnt = sat_inc(qual_cnt);
                            emit_byte(KIND_QUAL, b);
                            phase = P_QUAL;
                        end
                    end
                    P_QUAL: begin
                        if (lf) begin
                            emit_summary();
                            phase = P_REC_START;
                        end else if (!cr) begin
                            qual_cnt = sat_inc(qual_cnt);
                            emit_byte(KIND_QUAL, b);
                        end
                    end
                    default: halted = 1'b1;
                endcase
            end
        end
        // end of stream closes an open record and restarts the parser
        if (eos) begin
            if (!halted && phase >= P_IDENT) emit_summary();
            if (step_count > 0) step_tokens[step_count-1].last = 1'b1;
            reset_parser();
        end
    endfunction

    // ------------------------------------------------------------------
    // Stream generation
    // ------------------------------------------------------------------
    string nucleotides = "ACGTNacgtn";

    function automatic void add_byte(input logic [7:0] b);
        stream_bytes.insert(stream_bytes.size(), b);
    endfunction

    function automatic void add_line_end();
        if ($urandom_range(0, 3) == 0) add_byte(CH_CR);
        add_byte(CH_LF);
    endfunction

    // any byte that does not end an identifier
    function automatic logic [7:0] ident_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF);
        return c;
    endfunction

    function automatic logic [7:0] seq_byte();
        logic [7:0] c;
        if ($urandom_range(0, 6) != 0) c = nucleotides[$urandom_range(0, 9)];
        else c = ident_byte();
        if (c == MARK_FASTA) c = "N";
        return c;
    endfunction

    function automatic void add_header(input logic [7:0] marker);
        add_byte(marker);
        repeat ($urandom_range(0, 6)) add_byte(ident_byte());
        // optional description after the identifier
        if ($urandom_range(0, 1) == 1) begin
            case ($urandom_range(0, 2))
                0:       add_byte(CH_SPACE);
                1:       add_byte(CH_TAB);
                default: add_byte(CH_CR);
            endcase
            repeat ($urandom_range(0, 5)) add_byte(8'($urandom_range(11, 255)));
        end
        add_line_end();
    endfunction

    function automatic void add_trailing_spaces();
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 2)) add_byte(CH_SPACE);
    endfunction

    function automatic void fastq_record(input logic last_rec);
        add_header(MARK_FASTQ);
        if ($urandom_range(0, 6) == 0) add_line_end();
        if ($urandom_range(0, 19) != 0)
            repeat ($urandom_range(1, 10)) add_byte(seq_byte());
        add_trailing_spaces();
        add_line_end();
        if ($urandom_range(0, 6) == 0) add_line_end();
        add_byte("+");
        repeat ($urandom_range(0, 3)) add_byte(ident_byte());
        add_line_end();
        if ($urandom_range(0, 6) == 0) add_line_end();
        repeat ($urandom_range(1, 10)) add_byte(8'($urandom_range(33, 126)));
        if (!last_rec || $urandom_range(0, 1) == 1) add_line_end();
    endfunction

    function automatic void fasta_record(input logic last_rec);
        int lines;
        lines = $urandom_range(0, 3);
        add_header(MARK_FASTA);
        for (int l = 0; l < lines; l++) begin
            repeat ($urandom_range(0, 8)) add_byte(seq_byte());
            add_trailing_spaces();
            if (!(last_rec && l == lines - 1) || $urandom_range(0, 1) == 1) add_line_end();
        end
    endfunction

    // Mostly well-formed streams, some noise, broken starts and cut-off tails
    function automatic void build_stream();
        int recs, pick;
        stream_bytes.delete();
        pick = $urandom_range(0, 19);
        recs = $urandom_range(1, 4);
        if (pick < 9) begin
            for (int i = 0; i < recs; i++) begin
                if (i > 0 && $urandom_range(0, 2) == 0) begin
                    case ($urandom_range(0, 2))
                        0:       add_byte(CH_LF);
                        1:       add_byte(CH_CR);
                        default: add_byte(CH_SPACE);
                    endcase
                end
                if (i > 0 && $urandom_range(0, 19) == 0)
                    add_byte(8'($urandom_range(0, 255)));
                fastq_record(i == recs - 1);
            end
        end else if (pick < 18) begin
            if ($urandom_range(0, 3) == 0)
                add_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
            if ($urandom_range(0, 19) == 0)
                add_byte(8'($urandom_range(0, 255)));
            for (int i = 0; i < recs; i++) fasta_record(i == recs - 1);
        end else begin
            repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) == 0 && stream_bytes.size() > 1)
            repeat ($urandom_range(1, stream_bytes.size() - 1)) void'(stream_bytes.pop_back());
    endfunction

    // ------------------------------------------------------------------
    // Directed script helpers
    // ------------------------------------------------------------------
    function automatic void plan(input logic [7:0] data, input logic eos);
        t_script_row r;
        r.data      = data;
        r.eos       = eos;
        r.typed     = 1'b0;
        r.has_token = 1'b0;
        r.token     = '0;
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    function automatic void plan_typed(input logic [7:0] data, input logic eos,
                                       input logic has_token, input t_result token);
        t_script_row r;
        r.data      = data;
        r.eos       = eos;
        r.typed     = 1'b1;
        r.has_token = has_token;
        r.token     = token;
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    function automatic t_result make_result(input t_kind kind, input logic [7:0] data,
                                            input int id, input int sq, input int ql,
                                            input logic valid, input logic fq,
                                            input logic last);
        t_result r;
        r.kind        = kind;
        r.data        = data;
        r.ident_len   = LEN_OUT_W'(id);
        r.seq_len     = LEN_OUT_W'(sq);
        r.quality_len = LEN_OUT_W'(ql);
        r.rec_valid   = valid;
        r.fastq       = fq;
        r.last        = last;
        return r;
    endfunction

    function automatic string token_text(input t_result r);
        return $sformatf("kind=%0d byte=%02h id=%0d seq=%0d qual=%0d valid=%b fastq=%b last=%b",
                         r.kind, r.data, r.ident_len, r.seq_len, r.quality_len,
                         r.rec_valid, r.fastq, r.last);
    endfunction

    // ------------------------------------------------------------------
    // Input side: offer one byte, record expectations on acceptance
    // ------------------------------------------------------------------
    task automatic drive_byte(input logic [7:0] b, input logic eos, input logic typed,
                              input logic has_token, input t_result token);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= eos;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        tokenize_byte(b, eos);
        if (typed) begin
            if (has_token) expected_tokens.insert(expected_tokens.size(), token);
        end else begin
            for (int k = 0; k < step_count; k++)
                expected_tokens.insert(expected_tokens.size(), step_tokens[k]);
        end
        bytes_sent++;
        // random gap before the next byte
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
    endtask

    // Stop offering and wait until every expected item has come out
    task automatic drain_outputs();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_tokens.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Output side: random ready, plus long hold-offs on request
    // ------------------------------------------------------------------
    int hold_left  = 0;
    int hold_taken = 0;

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_m_tready <= 1'b0;
            hold_left  <= hold_left - 1;
        end else if (hold_taken != hold_requests) begin
            hold_taken <= hold_requests;
            hold_left  <= LONG_HOLD;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= i_rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Item checker and watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : token_check
        t_result got, want;
        int      quiet_cycles;
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
                    $display("fasta_fastq_record_tokenizer test failed");
                    $finish;
                end
            end
            if (o_m_tvalid && i_m_tready) begin
                got.kind        = t_kind'(o_m_tuser);
                got.data        = o_m_tdata[7:0];
                got.ident_len   = o_m_tdata[39:8];
                got.seq_len     = o_m_tdata[71:40];
                got.quality_len = o_m_tdata[103:72];
                got.rec_valid   = o_m_tdata[104];
                got.fastq       = o_m_tdata[105];
                got.last        = o_m_tlast;
                if (o_m_tdata[111:106] !== '0) begin
                    $display("%0t: padding bits expected 00, got %h",
                             $time, o_m_tdata[111:106]);
                    mismatch_count++;
                end
                if (expected_tokens.size() == 0) begin
                    $display("%0t: unexpected item, expected none, got %s",
                             $time, token_text(got));
                    mismatch_count++;
                end else begin
                    want = expected_tokens.pop_front();
                    if (got !== want) begin
                        $display("%0t: item mismatch, expected %s, got %s",
                                 $time, token_text(want), token_text(got));
                        mismatch_count++;
                    end
                end
            end
        end else begin
            quiet_cycles = 0;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_script_row row;

        reset_parser();

        // FASTQ record: high identifier byte, header rest, blank line,
        // trailing space, dropped CR, unchecked plus line
        plan_typed(MARK_FASTQ, 1'b0, 1'b0, '0);
        plan_typed(8'hFF, 1'b0, 1'b1,
                   make_result(KIND_IDENT, 8'hFF, 0, 0, 0, 1'b0, 1'b1, 1'b0));
        plan(CH_TAB, 1'b0);
        plan(8'h00, 1'b0);
        plan(CH_LF, 1'b0);
        plan(CH_LF, 1'b0);
        plan("A", 1'b0);
        plan(CH_SPACE, 1'b0);
        plan(CH_CR, 1'b0);
        plan(CH_LF, 1'b0);
        plan("+", 1'b0);
        plan(CH_LF, 1'b0);
        plan("I", 1'b0);
        plan_typed(CH_LF, 1'b0, 1'b1,
                   make_result(KIND_SUMMARY, 8'h00, 1, 1, 1, 1'b1, 1'b1, 1'b0));
        // space between records, then end of stream inside an identifier
        plan(CH_SPACE, 1'b0);
        plan(MARK_FASTQ, 1'b0);
        plan("q", 1'b1);
        // FASTA: record closed by the next marker, CR ending an empty identifier,
        // end of stream inside the sequence
        plan(MARK_FASTA, 1'b0);
        plan("B", 1'b0);
        plan(CH_LF, 1'b0);
        plan("C", 1'b0);
        plan(MARK_FASTA, 1'b0);
        plan(CH_CR, 1'b0);
        plan(CH_LF, 1'b0);
        plan("x", 1'b1);
        // wrong record start halts, everything after is ignored
        plan_typed("Z", 1'b0, 1'b0, '0);
        plan_typed(MARK_FASTQ, 1'b1, 1'b0, '0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    send_idle_pct  = 14;
                    recv_idle_pct <= 88;
                end
                1: begin
                    send_idle_pct  = 88;
                    recv_idle_pct <= 14;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_idle_pct <= 0;
                end
            endcase

            if (p == 0) begin
                foreach (directed_rows[i]) begin
                    row = directed_rows[i];
                    drive_byte(row.data, row.eos, row.typed, row.has_token, row.token);
                end
            end else begin
                // sender pauses until the block has emptied
                drain_outputs();
            end

            // long receiver hold-off while the sender keeps offering bytes
            if (p != 1) hold_requests <= hold_requests + 1;

            while (bytes_sent < PHASE_BYTES * (p + 1)) begin
                build_stream();
                for (int i = 0; i < stream_bytes.size(); i++)
                    drive_byte(stream_bytes[i], i == stream_bytes.size() - 1,
                               1'b0, 1'b0, '0);
            end
        end

        drain_outputs();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("fasta_fastq_record_tokenizer test passed");
        end else begin
            $display("fasta_fastq_record_tokenizer test failed");
        end
        $finish;
    end

endmodule

// ===== fasta_fastq_record_tokenizer.f =====
rtl/ffrt_pkg.sv
rtl/ffrt_front.sv
rtl/ffrt_queue.sv
rtl/ffrt_back.sv
rtl/fasta_fastq_record_tokenizer.sv
sim/tb.sv
